// ===== sv/hdt_pkg.sv =====
// shared types, codes and constants of the divider/timer block
`timescale 1ns / 1ps
`default_nettype none
package hdt_pkg;

	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	localparam logic [1:0] SEL_DIV  = 2'd0;
	localparam logic [1:0] SEL_TIMA = 2'd1;
	localparam logic [1:0] SEL_TMA  = 2'd2;
	localparam logic [1:0] SEL_TAC  = 2'd3;

	localparam int CD_W = 12;
	localparam logic [CD_W-1:0] CD_RESET = 12'd1024;
	localparam int TAC_EN_BIT = 2;
	localparam logic [7:0] TIMA_MAX = 8'd255;

	typedef struct packed {
		logic [1:0] op;
		logic [1:0] reg_sel;
		logic [7:0] write_data;
		logic [7:0] cycles;
	} item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       timer_irq;
		logic [7:0] divider_now;
		logic [7:0] counter_now;
	} result_t;

	function automatic logic [CD_W-1:0] period_of(input logic [1:0] rate);
		logic [CD_W-1:0] p;
		case (rate)
			2'd0:    p = 12'd1024;
			2'd1:    p = 12'd16;
			2'd2:    p = 12'd64;
			default: p = 12'd256;
		endcase
		return p;
	endfunction

endpackage
`default_nettype wire

// ===== sv/handheld_divider_timer_top.sv =====
// top level of the divider/timer block: input register, update, result register
// Each input word is a tick, a register write or a register read, and yields exactly one
// result word. A word is taken into the input register, updated against the timer state in
// one pass of logic and written to the result register when stage one advances, which waits
// while the result register is full and not being drained. One word per cycle is sustained
// while out_ready is high; the input side keeps taking words while the result
// register is held, until both stages are full.
`timescale 1ns / 1ps
`default_nettype none
module handheld_divider_timer_top
	import hdt_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] op,
	input  wire logic [1:0] reg_sel,
	input  wire logic [7:0] write_data,
	input  wire logic [7:0] cycles,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      read_data,
	output logic            timer_irq,
	output logic [7:0]      divider_now,
	output logic [7:0]      counter_now
);

	logic    valid_s1;
	item_t   item_s1;
	logic    valid_s2;
	result_t res_s2;
	result_t res;
	logic    advance;

	// stage one moves on when the result register is empty or being drained
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= '{op: op, reg_sel: reg_sel, write_data: write_data, cycles: cycles};
		end
	end

	hdt_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign out_valid   = valid_s2;
	assign read_data   = res_s2.read_data;
	assign timer_irq   = res_s2.timer_irq;
	assign divider_now = res_s2.divider_now;
	assign counter_now = res_s2.counter_now;

endmodule
`default_nettype wire

// ===== sv/hdt_core.sv =====
// timer state registers and the single-pass update for one word
`timescale 1ns / 1ps
`default_nettype none
module hdt_core
	import hdt_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    step,
	input  wire item_t   item,
	output result_t      res
);

	logic [7:0]      div_q, tima_q, tma_q;
	logic [2:0]      tac_q;
	logic [CD_W-1:0] cd_q;

	logic [7:0]      div_d, tima_d, tma_d;
	logic [2:0]      tac_d;
	logic [CD_W-1:0] cd_d;
	logic [7:0]      rd;
	logic            irq;
	logic [8:0]      div_sum;
	logic [CD_W:0]   cd_diff;
	logic            expired;

	assign div_sum = {1'b0, div_q} + {5'd0, item.cycles[7:4]};
	// sign-extended countdown minus the elapsed cycles
	assign cd_diff = {cd_q[CD_W-1], cd_q} - {{(CD_W-7){1'b0}}, item.cycles};
	assign expired = cd_diff[CD_W] || (cd_diff == '0);

	always_comb begin
		div_d  = div_q;
		tima_d = tima_q;
		tma_d  = tma_q;
		tac_d  = tac_q;
		cd_d   = cd_q;
		rd     = 8'd0;
		irq    = 1'b0;
		case (item.op)
			OP_TICK: begin
				// on overflow the step snaps to zero instead of wrapping
				div_d = div_sum[8] ? 8'd0 : div_sum[7:0];
				if (tac_q[TAC_EN_BIT]) begin
					cd_d = cd_diff[CD_W-1:0];
					if (expired) begin
						cd_d = period_of(tac_q[1:0]);
						if (tima_q == TIMA_MAX) begin
							tima_d = tma_q;
							irq    = 1'b1;
						end else begin
							tima_d = tima_q + 8'd1;
						end
					end
				end
			end
			OP_WRITE: begin
				unique case (item.reg_sel)
					SEL_DIV:  div_d  = 8'd0;
					SEL_TIMA: tima_d = item.write_data;
					SEL_TMA:  tma_d  = item.write_data;
					SEL_TAC:  tac_d  = item.write_data[2:0];
					default:  tac_d  = item.write_data[2:0];
				endcase
			end
			OP_READ: begin
				unique case (item.reg_sel)
					SEL_DIV:  rd = div_q;
					SEL_TIMA: rd = tima_q;
					SEL_TMA:  rd = tma_q;
					SEL_TAC:  rd = {5'd0, tac_q};
					default:  rd = {5'd0, tac_q};
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_q  <= 8'd0;
			tima_q <= 8'd0;
			tma_q  <= 8'd0;
			tac_q  <= 3'd0;
			cd_q   <= CD_RESET;
		end else if (step) begin
			div_q  <= div_d;
			tima_q <= tima_d;
			tma_q  <= tma_d;
			tac_q  <= tac_d;
			cd_q   <= cd_d;
		end
	end

	assign res.read_data   = rd;
	assign res.timer_irq   = irq;
	assign res.divider_now = div_d;
	assign res.counter_now = tima_d;

endmodule
`default_nettype wire
